// ===== rtl/sparse_span_encoder_with_bbox_macros.svh =====
// Assertion macros shared by the span encoder RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef SPARSE_SPAN_ENCODER_WITH_BBOX_MACROS_SVH
`define SPARSE_SPAN_ENCODER_WITH_BBOX_MACROS_SVH

`ifndef ASSERT_OFF
`define SSE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sse assertion failed");
`define SSE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sse forbidden condition seen");
`else
`define SSE_ASSERT(name, clk, rst_n, prop)
`define SSE_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== rtl/sse_pkg.sv =====
// Shared types, constants and helpers for the span encoder.
// No dependencies; used by sse_core, sse_emit and the top level.
package sse_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  // largest size an 11-bit size register can hold
  localparam int unsigned CFG_SIZE_MAX   = 2047;

  localparam int unsigned ADDR_W  = 22;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned BOX_W   = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned CFG_W   = 16;

  localparam logic [ADDR_W-1:0] WP_RESET    = 22'd2;
  localparam logic [ADDR_W-1:0] HDR_LO_ADDR = 22'd0;
  localparam logic [ADDR_W-1:0] HDR_HI_ADDR = 22'd1;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KEY    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_WORD    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One pixel's worth of work, expanded into word writes by sse_emit.
  typedef struct packed {
    logic                run_new;
    logic                run_ext;
    logic                img_end;
    logic [WORD_W-1:0]   pixel;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [ADDR_W-1:0]   wp;
    logic [ADDR_W-1:0]   la;
    logic [LEN_W-1:0]    run_len;
    logic [ADDR_W-1:0]   end_wp;
    logic                box_vld;
    logic [COORD_W-1:0]  min_col;
    logic [COORD_W-1:0]  max_col;
    logic [COORD_W-1:0]  min_row;
    logic [COORD_W-1:0]  max_row;
  } rec_t;

  // Last column/row index for a size register value: zero reads as one,
  // anything above lim reads as lim.
  function automatic logic [15:0] clamp_last(input logic [SIZE_W-1:0] v,
                                             input int unsigned lim);
    int unsigned c;
    c = 32'(v);
    if (c == 0) c = 1;
    if (c > lim) c = lim;
    return 16'(c - 32'd1);
  endfunction

endpackage

// ===== rtl/sse_core.sv =====
// Pixel stage: input register, run/box/position state and the per-pixel
// request record register. Depends on sse_pkg and the assertion macros.
`include "sparse_span_encoder_with_bbox_macros.svh"

module sse_core #(
  parameter int unsigned MAX_WIDTH  = sse_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sse_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [sse_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic [sse_pkg::WORD_W-1:0] pixel_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output sse_pkg::rec_t              rec_o,
  output logic                       rec_valid_o,
  input  logic                       rec_take_i
);

  localparam int unsigned EFF_W = (MAX_WIDTH < sse_pkg::CFG_SIZE_MAX) ?
                                  MAX_WIDTH : sse_pkg::CFG_SIZE_MAX;
  localparam int unsigned EFF_H = (MAX_HEIGHT < sse_pkg::CFG_SIZE_MAX) ?
                                  MAX_HEIGHT : sse_pkg::CFG_SIZE_MAX;
  localparam int unsigned COL_W = (EFF_W > 1) ? $clog2(EFF_W) : 1;
  localparam int unsigned ROW_W = (EFF_H > 1) ? $clog2(EFF_H) : 1;
  localparam int unsigned CW    = sse_pkg::COORD_W;
  localparam int unsigned AW    = sse_pkg::ADDR_W;
  localparam int unsigned LW    = sse_pkg::LEN_W;

  logic [sse_pkg::WORD_W-1:0] key_q;
  logic [COL_W-1:0]           col_last_q;
  logic [ROW_W-1:0]           row_last_q;

  logic [sse_pkg::WORD_W-1:0] pix_q;
  logic                       pix_vld_q, pix_vld_d;

  logic [COL_W-1:0] column_q, column_d, min_col_q, min_col_d, max_col_q, max_col_d;
  logic [ROW_W-1:0] row_q, row_d, min_row_q, min_row_d, max_row_q, max_row_d;
  logic             in_run_q, in_run_d, box_vld_q, box_vld_d;
  logic [LW-1:0]    run_len_q, run_len_d;
  logic [AW-1:0]    len_addr_q, len_addr_d, wr_ptr_q, wr_ptr_d;

  sse_pkg::rec_t rec_q, rec_d;
  logic          rec_vld_q, rec_vld_d;

  logic fire, in_acc, nonkey, row_end, img_end;

  assign fire       = pix_vld_q && (!rec_vld_q || rec_take_i);
  assign in_stall_o = pix_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign rec_o       = rec_q;
  assign rec_valid_o = rec_vld_q;

  assign nonkey  = pix_q != key_q;
  assign row_end = column_q >= col_last_q;
  assign img_end = row_end && (row_q >= row_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      col_last_q <= COL_W'(sse_pkg::clamp_last(11'd1024, MAX_WIDTH));
      row_last_q <= ROW_W'(sse_pkg::clamp_last(11'd1024, MAX_HEIGHT));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sse_pkg::CFG_WIDTH: begin
          col_last_q <= COL_W'(sse_pkg::clamp_last(cfg_data_i[10:0], MAX_WIDTH));
        end
        sse_pkg::CFG_HEIGHT: begin
          row_last_q <= ROW_W'(sse_pkg::clamp_last(cfg_data_i[10:0], MAX_HEIGHT));
        end
        sse_pkg::CFG_KEY: begin
          key_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Next image state and the record for the pixel in the input register.
  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    in_run_d   = in_run_q;
    run_len_d  = run_len_q;
    len_addr_d = len_addr_q;
    wr_ptr_d   = wr_ptr_q;
    min_col_d  = min_col_q;
    max_col_d  = max_col_q;
    min_row_d  = min_row_q;
    max_row_d  = max_row_q;
    box_vld_d  = box_vld_q;
    rec_d      = '0;

    rec_d.pixel = pix_q;
    rec_d.col   = CW'(column_q);
    rec_d.row   = CW'(row_q);
    rec_d.wp    = wr_ptr_q;

    if (nonkey) begin
      if (!box_vld_q) begin
        min_col_d = column_q;
        max_col_d = column_q;
        min_row_d = row_q;
        max_row_d = row_q;
        box_vld_d = 1'b1;
      end else begin
        if (column_q < min_col_q) min_col_d = column_q;
        if (column_q > max_col_q) max_col_d = column_q;
        if (row_q < min_row_q) min_row_d = row_q;
        if (row_q > max_row_q) max_row_d = row_q;
      end
      if (in_run_q) begin
        rec_d.run_ext = 1'b1;
        rec_d.la      = len_addr_q;
        wr_ptr_d      = wr_ptr_q + AW'(1);
        run_len_d     = run_len_q + LW'(1);
        rec_d.run_len = run_len_d;
      end else begin
        rec_d.run_new = 1'b1;
        len_addr_d    = wr_ptr_q + AW'(2);
        rec_d.la      = len_addr_d;
        wr_ptr_d      = wr_ptr_q + AW'(4);
        run_len_d     = LW'(1);
        rec_d.run_len = run_len_d;
        in_run_d      = 1'b1;
      end
    end else begin
      in_run_d = 1'b0;
    end

    if (row_end) begin
      column_d = '0;
      in_run_d = 1'b0;
      if (img_end) begin
        rec_d.img_end = 1'b1;
        rec_d.end_wp  = wr_ptr_d;
        rec_d.box_vld = box_vld_d;
        rec_d.min_col = CW'(min_col_d);
        rec_d.max_col = CW'(max_col_d);
        rec_d.min_row = CW'(min_row_d);
        rec_d.max_row = CW'(max_row_d);
        // start the next image from scratch
        row_d      = '0;
        run_len_d  = '0;
        len_addr_d = '0;
        wr_ptr_d   = sse_pkg::WP_RESET;
        min_col_d  = '0;
        max_col_d  = '0;
        min_row_d  = '0;
        max_row_d  = '0;
        box_vld_d  = 1'b0;
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end else begin
      column_d = column_q + COL_W'(1);
    end
  end

  always_comb begin
    if (in_acc) pix_vld_d = 1'b1;
    else if (fire) pix_vld_d = 1'b0;
    else pix_vld_d = pix_vld_q;

    if (fire) rec_vld_d = nonkey || img_end;
    else if (rec_take_i) rec_vld_d = 1'b0;
    else rec_vld_d = rec_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q  <= 1'b0;
      rec_vld_q  <= 1'b0;
      column_q   <= '0;
      row_q      <= '0;
      in_run_q   <= 1'b0;
      run_len_q  <= '0;
      len_addr_q <= '0;
      wr_ptr_q   <= sse_pkg::WP_RESET;
      min_col_q  <= '0;
      max_col_q  <= '0;
      min_row_q  <= '0;
      max_row_q  <= '0;
      box_vld_q  <= 1'b0;
    end else begin
      pix_vld_q <= pix_vld_d;
      rec_vld_q <= rec_vld_d;
      if (fire) begin
        column_q   <= column_d;
        row_q      <= row_d;
        in_run_q   <= in_run_d;
        run_len_q  <= run_len_d;
        len_addr_q <= len_addr_d;
        wr_ptr_q   <= wr_ptr_d;
        min_col_q  <= min_col_d;
        max_col_q  <= max_col_d;
        min_row_q  <= min_row_d;
        max_row_q  <= max_row_d;
        box_vld_q  <= box_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) pix_q <= pixel_i;
    if (fire) rec_q <= rec_d;
  end

  `SSE_ASSERT(a_rec_has_work, clk_i, rst_ni,
              rec_vld_q |-> (rec_q.run_new || rec_q.run_ext || rec_q.img_end))
  `SSE_ASSERT_NEVER(a_rec_one_run_kind, clk_i, rst_ni,
                    rec_vld_q && rec_q.run_new && rec_q.run_ext)
  `SSE_ASSERT(a_img_end_clears, clk_i, rst_ni,
              (fire && img_end) |=> (wr_ptr_q == sse_pkg::WP_RESET && !box_vld_q))

endmodule

// ===== rtl/sse_emit.sv =====
// Request expander: walks a pixel record into word writes and image summary,
// one per unstalled cycle, into the output register. Needs sse_pkg, macros.
`include "sparse_span_encoder_with_bbox_macros.svh"

module sse_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sse_pkg::rec_t               rec_i,
  input  logic                        rec_valid_i,
  output logic                        rec_take_o,
  output logic                        kind_o,
  output logic [sse_pkg::ADDR_W-1:0]  word_addr_o,
  output logic [sse_pkg::WORD_W-1:0]  word_value_o,
  output logic [sse_pkg::BOX_W-1:0]   box_x_o,
  output logic [sse_pkg::BOX_W-1:0]   box_y_o,
  output logic [sse_pkg::SIZE_W-1:0]  box_width_o,
  output logic [sse_pkg::SIZE_W-1:0]  box_height_o,
  output logic                        box_empty_o,
  output logic                        last_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);

  localparam int unsigned AW = sse_pkg::ADDR_W;
  localparam int unsigned WW = sse_pkg::WORD_W;
  localparam int unsigned BW = sse_pkg::BOX_W;
  localparam int unsigned SW = sse_pkg::SIZE_W;

  sse_pkg::rec_t cur_q;
  logic          cur_vld_q, cur_vld_d;
  logic [2:0]    step_q, step_d;

  logic [2:0] npx, total, end_step;
  logic       out_ready, emit, step_last, done;

  sse_pkg::kind_e    w_kind;
  logic [AW-1:0]     w_addr;
  logic [WW-1:0]     w_value;
  logic [BW-1:0]     w_box_x, w_box_y;
  logic [SW-1:0]     w_box_w, w_box_h;
  logic              w_empty;

  sse_pkg::kind_e    kind_q;
  logic [AW-1:0]     addr_q;
  logic [WW-1:0]     value_q;
  logic [BW-1:0]     box_x_q, box_y_q;
  logic [SW-1:0]     box_w_q, box_h_q;
  logic              empty_q, last_q;
  logic              out_vld_q, out_vld_d;

  // new run: x, y, length, pixel; growing run: pixel, length; image end: 3 more
  assign npx       = cur_q.run_new ? 3'd4 : (cur_q.run_ext ? 3'd2 : 3'd0);
  assign total     = npx + (cur_q.img_end ? 3'd3 : 3'd0);
  assign end_step  = step_q - npx;
  assign step_last = step_q == (total - 3'd1);

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign emit       = cur_vld_q && out_ready;
  assign done       = emit && step_last;
  assign rec_take_o = rec_valid_i && (!cur_vld_q || done);

  always_comb begin
    w_kind  = sse_pkg::KIND_WORD;
    w_addr  = '0;
    w_value = '0;
    w_box_x = '0;
    w_box_y = '0;
    w_box_w = '0;
    w_box_h = '0;
    w_empty = 1'b0;
    if (step_q < npx) begin
      if (cur_q.run_new) begin
        w_addr = cur_q.wp + AW'(step_q[1:0]);
        case (step_q[1:0])
          2'd0:    w_value = WW'(cur_q.col);
          2'd1:    w_value = WW'(cur_q.row);
          2'd2:    w_value = WW'(1);
          default: w_value = cur_q.pixel;
        endcase
      end else if (step_q[0]) begin
        w_addr  = cur_q.la;
        w_value = WW'(cur_q.run_len);
      end else begin
        w_addr  = cur_q.wp;
        w_value = cur_q.pixel;
      end
    end else begin
      case (end_step[1:0])
        2'd0: begin
          w_addr  = sse_pkg::HDR_LO_ADDR;
          w_value = cur_q.end_wp[15:0];
        end
        2'd1: begin
          w_addr  = sse_pkg::HDR_HI_ADDR;
          w_value = WW'(cur_q.end_wp[AW-1:16]);
        end
        default: begin
          w_kind = sse_pkg::KIND_SUMMARY;
          if (cur_q.box_vld) begin
            w_box_x = cur_q.min_col[BW-1:0];
            w_box_y = cur_q.min_row[BW-1:0];
            w_box_w = SW'(cur_q.max_col - cur_q.min_col + SW'(1));
            w_box_h = SW'(cur_q.max_row - cur_q.min_row + SW'(1));
          end else begin
            w_empty = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (rec_take_o) cur_vld_d = 1'b1;
    else if (done) cur_vld_d = 1'b0;
    else cur_vld_d = cur_vld_q;

    if (rec_take_o || done) step_d = '0;
    else if (emit) step_d = step_q + 3'd1;
    else step_d = step_q;

    if (emit) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) cur_q <= rec_i;
    if (emit) begin
      kind_q  <= w_kind;
      addr_q  <= w_addr;
      value_q <= w_value;
      box_x_q <= w_box_x;
      box_y_q <= w_box_y;
      box_w_q <= w_box_w;
      box_h_q <= w_box_h;
      empty_q <= w_empty;
      last_q  <= step_last;
    end
  end

  assign kind_o       = kind_q;
  assign word_addr_o  = addr_q;
  assign word_value_o = value_q;
  assign box_x_o      = box_x_q;
  assign box_y_o      = box_y_q;
  assign box_width_o  = box_w_q;
  assign box_height_o = box_h_q;
  assign box_empty_o  = empty_q;
  assign last_o       = last_q;
  assign out_valid_o  = out_vld_q;

  `SSE_ASSERT(a_cur_not_empty, clk_i, rst_ni, cur_vld_q |-> (total != 3'd0))
  `SSE_ASSERT(a_step_in_range, clk_i, rst_ni, cur_vld_q |-> (step_q < total))
  `SSE_ASSERT(a_summary_is_last, clk_i, rst_ni,
              (out_vld_q && kind_q == sse_pkg::KIND_SUMMARY) |-> last_q)

endmodule

// ===== rtl/sparse_span_encoder_with_bbox.sv =====
// Span encoder: a pixel passes the input, record, expander and output registers.
// Results leave on the single result port: none for a key pixel (one pixel per
// cycle while no earlier record waits), two to grow a run, four to open a run,
// plus three at the last pixel of the image; out_stall_i can hold them.
// Reset: 1024x1024 image, key 0, counters cleared, write pointer at 2.
module sparse_span_encoder_with_bbox #(
  parameter int unsigned MAX_WIDTH  = sse_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sse_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [sse_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [sse_pkg::WORD_W-1:0]  pixel_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  output logic                        kind_o,
  output logic [sse_pkg::ADDR_W-1:0]  word_addr_o,
  output logic [sse_pkg::WORD_W-1:0]  word_value_o,
  output logic [sse_pkg::BOX_W-1:0]   box_x_o,
  output logic [sse_pkg::BOX_W-1:0]   box_y_o,
  output logic [sse_pkg::SIZE_W-1:0]  box_width_o,
  output logic [sse_pkg::SIZE_W-1:0]  box_height_o,
  output logic                        box_empty_o,
  output logic                        last_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);

  sse_pkg::rec_t rec;
  logic          rec_valid, rec_take;

  sse_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rec_o       (rec),
    .rec_valid_o (rec_valid),
    .rec_take_i  (rec_take)
  );

  sse_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (rec),
    .rec_valid_i  (rec_valid),
    .rec_take_o   (rec_take),
    .kind_o       (kind_o),
    .word_addr_o  (word_addr_o),
    .word_value_o (word_value_o),
    .box_x_o      (box_x_o),
    .box_y_o      (box_y_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .box_empty_o  (box_empty_o),
    .last_o       (last_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule
